/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, clocked on clk, off during reset.
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/hscf_pkg.sv */
// Package: types and constants of the sphere contact force block.
`default_nettype none
package hscf_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;
    localparam int CFG_IDX_BITS  = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_CENTRE_X      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTRE_Y      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CENTRE_Z      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPHERE_RADIUS = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_CURSOR_RADIUS = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPRING_GAIN   = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_FORCE_LIMIT   = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_SUM, ST_SQRT, ST_EVAL, ST_MULG,
        ST_NORM, ST_MULN, ST_DIVI, ST_DIV, ST_FIN
    } hscf_state_t;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_LOAD, CMD_SQ_STEP, CMD_SUM, CMD_SQRT_STEP, CMD_EVAL,
        CMD_MUL_STEP, CMD_NORM, CMD_DIV_INIT, CMD_DIV_STEP, CMD_OUT
    } hscf_cmd_t;
endpackage
`default_nettype wire

/* rtl/haptic_sphere_contact_force.sv */
// Sphere penalty force: penetration spring along the contact normal.
// Channels: input words (probe position, active, just_active) on in_valid/in_ready;
// result words (force vector, norm, inside_mode) on out_valid/out_ready;
// register writes on cfg_valid/cfg_ready, always ready, index 0..6 as listed,
// higher indexes ignored. Write registers only while the block is idle.
// One word at a time: in_ready is high only when no word is in work.
// After acceptance a word passes through the serial units: WORD_BITS+1 squaring
// steps, WORD_BITS+2 root steps, WORD_BITS gain multiply steps, WORD_BITS-1
// scaling steps and WORD_BITS-1 divide steps, each one bit per cycle, with the
// setup states SUM, EVAL, NORM and DIVI between them, then the output state FIN.
// The result register frees the engine: the next word is taken while a result
// waits; if the receiver stalls, the following word finishes and holds until the
// register is taken.
// Reset clears the handshakes, the inside latch (outside) and restores the
// register reset values.
`default_nettype none
module haptic_sphere_contact_force import hscf_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [WORD_BITS-1:0]    probe_x,
    input  wire logic [WORD_BITS-1:0]    probe_y,
    input  wire logic [WORD_BITS-1:0]    probe_z,
    input  wire logic                    active,
    input  wire logic                    just_active,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [WORD_BITS-1:0]         force_x,
    output logic [WORD_BITS-1:0]         force_y,
    output logic [WORD_BITS-1:0]         force_z,
    output logic [WORD_BITS-2:0]         force_norm,
    output logic                         inside_mode,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [WORD_BITS-1:0]    cfg_data
);
    hscf_cmd_t cmd;

    assign cfg_ready = 1'b1;

    hscf_ctrl #(.WORD_BITS(WORD_BITS)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    hscf_datapath #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .probe_x     (probe_x),
        .probe_y     (probe_y),
        .probe_z     (probe_z),
        .active      (active),
        .just_active (just_active),
        .force_x     (force_x),
        .force_y     (force_y),
        .force_z     (force_z),
        .force_norm  (force_norm),
        .inside_mode (inside_mode)
    );
endmodule
`default_nettype wire

/* rtl/hscf_ctrl.sv */
// Controller: sequences the shared serial datapath through one word.
`default_nettype none
module hscf_ctrl import hscf_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output hscf_cmd_t cmd
);
    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(W + 3);

    hscf_state_t   state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ov_reg, ov_next;
    logic          last;

    assign last = (cnt_reg == CW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg - CW'(1);
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = CW'(W + 1);
                if (in_valid)
                    state_next = ST_SQ;
            end
            ST_SQ:   if (last) state_next = ST_SUM;
            ST_SUM:
            begin
                cnt_next   = CW'(W + 2);
                state_next = ST_SQRT;
            end
            ST_SQRT: if (last) state_next = ST_EVAL;
            ST_EVAL:
            begin
                cnt_next   = CW'(W);
                state_next = ST_MULG;
            end
            ST_MULG: if (last) state_next = ST_NORM;
            ST_NORM:
            begin
                cnt_next   = CW'(W - 1);
                state_next = ST_MULN;
            end
            ST_MULN: if (last) state_next = ST_DIVI;
            ST_DIVI:
            begin
                cnt_next   = CW'(W - 1);
                state_next = ST_DIV;
            end
            ST_DIV:  if (last) state_next = ST_FIN;
            ST_FIN:  if (!ov_reg || out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = CMD_NONE;
        case (state_reg)
            ST_IDLE: if (in_valid) cmd = CMD_LOAD;
            ST_SQ:   cmd = CMD_SQ_STEP;
            ST_SUM:  cmd = CMD_SUM;
            ST_SQRT: cmd = CMD_SQRT_STEP;
            ST_EVAL: cmd = CMD_EVAL;
            ST_MULG: cmd = CMD_MUL_STEP;
            ST_NORM: cmd = CMD_NORM;
            ST_MULN: cmd = CMD_MUL_STEP;
            ST_DIVI: cmd = CMD_DIV_INIT;
            ST_DIV:  cmd = CMD_DIV_STEP;
            ST_FIN:  if (!ov_reg || out_ready) cmd = CMD_OUT;
            default: cmd = CMD_NONE;
        endcase
    end

    always_comb
    begin
        if (cmd == CMD_OUT)
            ov_next = 1'b1;
        else if (out_ready)
            ov_next = 1'b0;
        else
            ov_next = ov_reg;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ov_reg;
endmodule
`default_nettype wire

/* rtl/hscf_datapath.sv */
// Datapath: config registers, serial multiply lanes, square root, divide, output word.
`default_nettype none
module hscf_datapath import hscf_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  hscf_cmd_t                    cmd,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [WORD_BITS-1:0]    cfg_data,
    input  wire logic [WORD_BITS-1:0]    probe_x,
    input  wire logic [WORD_BITS-1:0]    probe_y,
    input  wire logic [WORD_BITS-1:0]    probe_z,
    input  wire logic                    active,
    input  wire logic                    just_active,
    output logic [WORD_BITS-1:0]         force_x,
    output logic [WORD_BITS-1:0]         force_y,
    output logic [WORD_BITS-1:0]         force_z,
    output logic [WORD_BITS-2:0]         force_norm,
    output logic                         inside_mode
);
    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int PW  = 2 * W + 4;
    localparam int MW  = W + 2;
    localparam int RW  = W + 2;
    localparam int RMW = W + 4;

    // config
    logic [W-1:0] cx_reg, cy_reg, cz_reg, gain_reg;
    logic [W-2:0] srad_reg, crad_reg, lim_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg   <= '0;
            cy_reg   <= '0;
            cz_reg   <= '0;
            srad_reg <= (W-1)'(5) << F;
            crad_reg <= (W-1)'(1) << F;
            gain_reg <= '0 - (W'(1) << F);
            lim_reg  <= (W-1)'(5) << F;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CENTRE_X:      cx_reg   <= cfg_data;
                REG_CENTRE_Y:      cy_reg   <= cfg_data;
                REG_CENTRE_Z:      cz_reg   <= cfg_data;
                REG_SPHERE_RADIUS: srad_reg <= cfg_data[W-2:0];
                REG_CURSOR_RADIUS: crad_reg <= cfg_data[W-2:0];
                REG_SPRING_GAIN:   gain_reg <= cfg_data;
                REG_FORCE_LIMIT:   lim_reg  <= cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    // per-item state
    logic [W:0]     dm_reg  [3];
    logic           ds_reg  [3];
    logic [PW-1:0]  mc_reg  [3];
    logic [MW-1:0]  mp_reg  [3];
    logic [PW-1:0]  acc_reg [3];
    logic [RW-1:0]  rem_reg [3];
    logic [W-2:0]   q_reg   [3];
    logic [PW-1:0]  n_reg;
    logic [RMW-1:0] srem_reg;
    logic [RW-1:0]  root_reg;
    logic           act_reg, just_reg, inside_reg, neg_reg, zero_reg;
    logic [W-2:0]   norm_reg;
    logic [W-1:0]   fx_reg, fy_reg, fz_reg;
    logic [W-2:0]   fn_reg;
    logic           im_reg;

    // load
    logic [W-1:0] pv [3];
    logic [W-1:0] cv [3];
    logic [W:0]   dsub [3];
    logic [W:0]   dmag [3];
    assign pv[0] = probe_x;
    assign pv[1] = probe_y;
    assign pv[2] = probe_z;
    assign cv[0] = cx_reg;
    assign cv[1] = cy_reg;
    assign cv[2] = cz_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dsub[i] = {pv[i][W-1], pv[i]} - {cv[i][W-1], cv[i]};
            dmag[i] = dsub[i][W] ? (~dsub[i] + (W+1)'(1)) : dsub[i];
        end
    end

    // square root step
    logic [RMW-1:0] sr2, strial;
    logic           sge;
    assign sr2    = {srem_reg[RMW-3:0], n_reg[PW-1 -: 2]};
    assign strial = {root_reg, 2'b01};
    assign sge    = (sr2 >= strial);

    // evaluation of penetration
    logic [W:0]   d, thr;
    logic [W+2:0] e;
    logic [MW-1:0] eabs;
    logic [W-1:0] gabs;
    logic         lat, epos, push, zero_n;
    assign d = root_reg[W:0];
    assign lat = just_reg ? (d < {2'b00, srad_reg}) : inside_reg;
    assign thr = lat ? ({2'b00, srad_reg} - {2'b00, crad_reg})
                     : ({2'b00, srad_reg} + {2'b00, crad_reg});
    assign e = {2'b00, d} - {{2{thr[W]}}, thr};
    assign eabs = e[W+2] ? MW'(~e + (W+3)'(1)) : MW'(e);
    assign gabs = gain_reg[W-1] ? (~gain_reg + W'(1)) : gain_reg;
    assign epos = !e[W+2] && (e != '0);
    assign push = act_reg && (d != '0) && (lat ? epos : e[W+2]);
    assign zero_n = !(push && (gain_reg != '0));

    // clamp
    logic [PW-1:0] hi;
    logic [W-2:0]  norm_n;
    assign hi = acc_reg[0] >> F;
    assign norm_n = zero_reg ? '0 : ((hi > PW'(lim_reg)) ? lim_reg : hi[W-2:0]);

    // divide step
    logic [RW:0] r2 [3];
    logic        dge [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            r2[i]  = {rem_reg[i], acc_reg[i][W-2]};
            dge[i] = (r2[i] >= {1'b0, root_reg});
        end
    end

    // output word
    logic [W-1:0] fo [3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (zero_reg)
                fo[i] = '0;
            else if (neg_reg ^ ds_reg[i])
                fo[i] = ~{1'b0, q_reg[i]} + W'(1);
            else
                fo[i] = {1'b0, q_reg[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inside_reg <= 1'b0;
        else if (cmd == CMD_EVAL)
            inside_reg <= lat;
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LOAD:
            begin
                act_reg  <= active;
                just_reg <= just_active;
                for (int i = 0; i < 3; i++)
                begin
                    dm_reg[i]  <= dmag[i];
                    ds_reg[i]  <= dsub[i][W];
                    mc_reg[i]  <= PW'(dmag[i]);
                    mp_reg[i]  <= MW'(dmag[i]);
                    acc_reg[i] <= '0;
                end
            end
            CMD_SQ_STEP, CMD_MUL_STEP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (mp_reg[i][0])
                        acc_reg[i] <= acc_reg[i] + mc_reg[i];
                    mc_reg[i] <= mc_reg[i] << 1;
                    mp_reg[i] <= mp_reg[i] >> 1;
                end
            end
            CMD_SUM:
            begin
                n_reg    <= acc_reg[0] + acc_reg[1] + acc_reg[2];
                srem_reg <= '0;
                root_reg <= '0;
            end
            CMD_SQRT_STEP:
            begin
                srem_reg <= sge ? (sr2 - strial) : sr2;
                root_reg <= {root_reg[RW-2:0], sge};
                n_reg    <= n_reg << 2;
            end
            CMD_EVAL:
            begin
                neg_reg    <= gain_reg[W-1] ^ e[W+2];
                zero_reg   <= zero_n;
                mc_reg[0]  <= PW'(eabs);
                mp_reg[0]  <= MW'(gabs);
                acc_reg[0] <= '0;
            end
            CMD_NORM:
            begin
                norm_reg <= norm_n;
                for (int i = 0; i < 3; i++)
                begin
                    mc_reg[i]  <= PW'(dm_reg[i]);
                    mp_reg[i]  <= MW'(norm_n);
                    acc_reg[i] <= '0;
                end
            end
            CMD_DIV_INIT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[i] <= acc_reg[i][W-1 +: RW];
                    q_reg[i]   <= '0;
                end
            end
            CMD_DIV_STEP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[i] <= dge[i] ? RW'(r2[i] - {1'b0, root_reg}) : r2[i][RW-1:0];
                    q_reg[i]   <= {q_reg[i][W-3:0], dge[i]};
                    acc_reg[i] <= acc_reg[i] << 1;
                end
            end
            CMD_OUT:
            begin
                fx_reg <= fo[0];
                fy_reg <= fo[1];
                fz_reg <= fo[2];
                fn_reg <= norm_reg;
                im_reg <= inside_reg;
            end
            default: ;
        endcase
    end

    assign force_x     = fx_reg;
    assign force_y     = fy_reg;
    assign force_z     = fz_reg;
    assign force_norm  = fn_reg;
    assign inside_mode = im_reg;
endmodule
`default_nettype wire

/* rtl/hscf_checker.sv */
// Port-level checker for the sphere contact force block, with its bind.
`default_nettype none
`include "assert_macros.svh"
module hscf_checker import hscf_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_ready,
    input wire logic [WORD_BITS-1:0]    probe_x,
    input wire logic [WORD_BITS-1:0]    probe_y,
    input wire logic [WORD_BITS-1:0]    probe_z,
    input wire logic                    active,
    input wire logic                    just_active,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic [WORD_BITS-1:0]    force_x,
    input wire logic [WORD_BITS-1:0]    force_y,
    input wire logic [WORD_BITS-1:0]    force_z,
    input wire logic [WORD_BITS-2:0]    force_norm,
    input wire logic                    inside_mode,
    input wire logic                    cfg_valid,
    input wire logic                    cfg_ready,
    input wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input wire logic [WORD_BITS-1:0]    cfg_data
);
    // a held result stays valid and keeps its norm
    `ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(force_norm))
    // zero norm means no force at all
    `ASSERT_IMP(a_zero_norm, out_valid && (force_norm == '0),
                (force_x == '0) && (force_y == '0) && (force_z == '0))
    // one word in work at a time
    `ASSERT_NXT(a_busy, in_valid && in_ready, !in_ready)
    // acceptance of a word is not followed at once by a rising out_valid
    `ASSERT_NXT(a_no_early, in_valid && in_ready, !($rose(out_valid)))
endmodule

bind haptic_sphere_contact_force hscf_checker #(.WORD_BITS(WORD_BITS)) u_chk (.*);
`default_nettype wire

/* test/tb_top.sv */
// Testbench for the sphere contact force block: random and directed probe words, scoreboard check.
`default_nettype none
class force_scoreboard;
    logic signed [31:0] centre [3];
    logic [30:0] sphere_r, cursor_r, f_limit;
    logic signed [31:0] gain;
    bit inside_latch;
    logic [31:0] exp_fx [$], exp_fy [$], exp_fz [$];
    logic [30:0] exp_norm [$];
    bit exp_inside [$];
    int errors;

    function new();
        reset_state();
        errors = 0;
    endfunction

    function void reset_state();
        centre[0] = 0; centre[1] = 0; centre[2] = 0;
        sphere_r = 31'd327680;
        cursor_r = 31'd65536;
        gain = -32'sd65536;
        f_limit = 31'd327680;
        inside_latch = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
        case (idx)
            hscf_pkg::REG_CENTRE_X:      centre[0] = data;
            hscf_pkg::REG_CENTRE_Y:      centre[1] = data;
            hscf_pkg::REG_CENTRE_Z:      centre[2] = data;
            hscf_pkg::REG_SPHERE_RADIUS: sphere_r = data[30:0];
            hscf_pkg::REG_CURSOR_RADIUS: cursor_r = data[30:0];
            hscf_pkg::REG_SPRING_GAIN:   gain = data;
            hscf_pkg::REG_FORCE_LIMIT:   f_limit = data[30:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return exp_norm.size();
    endfunction

    // predict the force for one accepted probe word
    function void note_probe(logic [31:0] p [3], bit act, bit just);
        logic signed [33:0] dv [3];
        logic [32:0] dm [3];
        logic [67:0] sq_sum, t2;
        logic [33:0] dlen, t;
        logic signed [35:0] e;
        logic [35:0] emag;
        logic [32:0] gmag;
        logic [67:0] prod, pshift;
        logic [30:0] nrm;
        logic [31:0] comp [3];
        logic [63:0] c;
        bit push, neg;
        sq_sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            dv[i] = $signed(p[i]) - $signed(centre[i]);
            dm[i] = dv[i] < 0 ? -dv[i] : dv[i];
            sq_sum += dm[i] * dm[i];
        end
        dlen = 0;
        for (int b = 33; b >= 0; b--)
        begin
            t = dlen | (34'd1 << b);
            t2 = t * t;
            if (t2 <= sq_sum) dlen = t;
        end
        if (just) inside_latch = $signed({2'b0, dlen}) < $signed({5'b0, sphere_r});
        if (inside_latch)
            e = $signed({2'b0, dlen}) - ($signed({5'b0, sphere_r}) - $signed({5'b0, cursor_r}));
        else
            e = $signed({2'b0, dlen}) - ($signed({5'b0, sphere_r}) + $signed({5'b0, cursor_r}));
        push = act && dlen != 0 && ((inside_latch && e > 0) || (!inside_latch && e < 0));
        nrm = 0;
        comp[0] = 0; comp[1] = 0; comp[2] = 0;
        if (push && gain != 0)
        begin
            neg = (gain < 0) != (e < 0);
            emag = e < 0 ? -e : e;
            gmag = {gain[31], gain};
            if (gain < 0) gmag = -gmag;
            prod = 68'(gmag) * 68'(emag);
            pshift = prod >> 16;
            nrm = pshift > f_limit ? f_limit : pshift[30:0];
            for (int i = 0; i < 3; i++)
            begin
                c = (64'(nrm) * 64'(dm[i])) / 64'(dlen);
                comp[i] = (neg != (dv[i] < 0)) ? -c[31:0] : c[31:0];
            end
        end
        exp_fx.push_back(comp[0]); exp_fy.push_back(comp[1]); exp_fz.push_back(comp[2]);
        exp_norm.push_back(nrm);
        exp_inside.push_back(inside_latch);
    endfunction

    function void check_force(logic [31:0] fx, logic [31:0] fy, logic [31:0] fz,
                              logic [30:0] nrm, bit ins);
        logic [31:0] ex, ey, ez;
        logic [30:0] en;
        bit ei;
        if (exp_norm.size() == 0)
        begin
            $display("%0t: unexpected result word fx=%h", $time, fx);
            errors++;
            return;
        end
        ex = exp_fx.pop_front(); ey = exp_fy.pop_front(); ez = exp_fz.pop_front();
        en = exp_norm.pop_front(); ei = exp_inside.pop_front();
        if (fx !== ex) begin $display("%0t: force_x exp %h got %h", $time, ex, fx); errors++; end
        if (fy !== ey) begin $display("%0t: force_y exp %h got %h", $time, ey, fy); errors++; end
        if (fz !== ez) begin $display("%0t: force_z exp %h got %h", $time, ez, fz); errors++; end
        if (nrm !== en) begin $display("%0t: force_norm exp %h got %h", $time, en, nrm); errors++; end
        if (ins !== ei)
        begin
            $display("%0t: inside_mode exp %b got %b", $time, ei, ins);
            errors++;
        end
    endfunction
endclass

module tb_top import hscf_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 20000;

    logic clk = 0, rst_n = 0;
    logic in_valid = 0, out_ready = 0, cfg_valid = 0;
    logic [31:0] probe_x = 0, probe_y = 0, probe_z = 0, cfg_data = 0;
    logic active = 0, just_active = 0;
    logic [2:0] cfg_index = 0;
    logic in_ready, out_valid, cfg_ready, inside_mode;
    logic [31:0] force_x, force_y, force_z;
    logic [30:0] force_norm;

    force_scoreboard board = new();
    int idle_cycles = 0;
    bit stim_done = 0;

    haptic_sphere_contact_force uut (.*);

    always #1 clk = ~clk;

    function automatic int gap_len();
        int r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 250);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_force(force_x, force_y, force_z, force_norm, inside_mode);
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver stalls: random gaps, some long
    initial
    begin
        bool_loop: forever
        begin
            @(negedge clk);
            if (stim_done && board.pending() == 0)
                out_ready <= 1;
            else
                out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
            if ($urandom_range(0, 60) == 0)
            begin
                @(negedge clk);
                out_ready <= 0;
                repeat ($urandom_range(20, 300)) @(negedge clk);
            end
        end
    end

    task automatic send_probe(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit act, bit just);
        logic [31:0] p [3];
        // at least one falling edge after the previous word drops in_valid
        repeat (gap_len() + 1) @(negedge clk);
        in_valid <= 1; probe_x <= x; probe_y <= y; probe_z <= z;
        active <= act; just_active <= just;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        p[0] = x; p[1] = y; p[2] = z;
        board.note_probe(p, act, just);
        @(negedge clk);
        in_valid <= 0;
    endtask

    task automatic drain();
        while (board.pending() != 0) @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    // well-formed contact session: activate with a latch, then wander near the surface
    task automatic session(int n);
        logic [31:0] base [3];
        int span;
        for (int i = 0; i < 3; i++) base[i] = board.centre[i];
        span = (board.sphere_r + board.cursor_r) + 31'h20000;
        for (int k = 0; k < n; k++)
        begin
            logic [31:0] off [3];
            for (int i = 0; i < 3; i++)
                off[i] = base[i] + $signed($urandom_range(0, 2 * span) - span);
            send_probe(off[0], off[1], off[2], $urandom_range(0, 9) != 0, k == 0);
        end
    endtask

    function automatic logic [31:0] rnd_word();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int cnt;
        int n;
        repeat (3) @(negedge clk);
        rst_n <= 1;
        // directed: defaults
        send_probe(0, 0, 0, 1, 1);                       // zero distance
        send_probe(32'h0003_0000, 0, 0, 1, 1);           // latch inside
        send_probe(32'h0004_8000, 0, 0, 1, 0);           // past inner surface
        send_probe(32'h0004_8000, 0, 0, 0, 0);           // inactive
        send_probe(0, 32'hfffa_0000, 0, 1, 1);           // outside latch
        send_probe(0, 32'hfffb_0000, 32'h0000_8000, 1, 0);
        send_probe(32'h0000_8000, 0, 0, 0, 1);           // latch while inactive
        send_probe(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1, 1);
        send_probe(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 0);
        send_probe(32'h8000_0000, 32'h7fff_ffff, 0, 1, 1);
        drain();
        // extremes of the registers
        write_cfg(REG_CENTRE_X, 32'h7fff_ffff);
        write_cfg(REG_CENTRE_Y, 32'h8000_0000);
        write_cfg(REG_CENTRE_Z, 32'h0001_0000);
        write_cfg(REG_SPHERE_RADIUS, 32'h7fff_ffff);
        write_cfg(REG_CURSOR_RADIUS, 32'hffff_ffff);
        write_cfg(REG_SPRING_GAIN, 32'h8000_0000);
        write_cfg(REG_FORCE_LIMIT, 32'h7fff_ffff);
        write_cfg(3'd7, 32'h1234_5678);                  // ignored index
        send_probe(0, 0, 0, 1, 1);
        send_probe(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1, 1);
        send_probe(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1, 0);
        drain();
        write_cfg(REG_SPHERE_RADIUS, 0);                 // cursor bigger than sphere
        write_cfg(REG_CURSOR_RADIUS, 32'h0002_0000);
        write_cfg(REG_SPRING_GAIN, 0);
        send_probe(32'h7fff_0000, 32'h8001_0000, 32'h0001_0000, 1, 1);
        drain();
        write_cfg(REG_SPRING_GAIN, 0);
        write_cfg(REG_SPRING_GAIN, 32'h7fff_ffff);
        write_cfg(REG_FORCE_LIMIT, 0);
        send_probe($urandom, $urandom, $urandom, 1, 1);
        drain();
        // random phases with varied settings
        cnt = 0;
        while (cnt < 500)
        begin
            write_cfg(REG_CENTRE_X, $urandom_range(0, 3) == 0 ? rnd_word() : $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
            write_cfg(REG_CENTRE_Y, $urandom_range(0, 3) == 0 ? rnd_word() : $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
            write_cfg(REG_CENTRE_Z, $urandom_range(0, 3) == 0 ? rnd_word() : $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
            write_cfg(REG_SPHERE_RADIUS, $urandom_range(0, 9) == 0 ? rnd_word() : $urandom_range(0, 32'h000f_ffff));
            write_cfg(REG_CURSOR_RADIUS, $urandom_range(0, 9) == 0 ? rnd_word() : $urandom_range(0, 32'h0003_ffff));
            write_cfg(REG_SPRING_GAIN, $urandom_range(0, 4) == 0 ? rnd_word() : -$urandom_range(0, 32'h000f_ffff));
            write_cfg(REG_FORCE_LIMIT, $urandom_range(0, 4) == 0 ? rnd_word() : $urandom_range(0, 32'h000f_ffff));
            for (int s = 0; s < 4; s++)
            begin
                n = $urandom_range(5, 15);
                if ($urandom_range(0, 4) == 0)
                    for (int k = 0; k < n; k++)
                        send_probe(rnd_word(), rnd_word(), rnd_word(), $urandom, $urandom);
                else
                    session(n);
                cnt += n;
            end
            drain();
        end
        stim_done = 1;
        drain();
        if (board.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

/* sim.f */
+incdir+rtl
rtl/hscf_pkg.sv
rtl/hscf_ctrl.sv
rtl/hscf_datapath.sv
rtl/haptic_sphere_contact_force.sv
rtl/hscf_checker.sv
test/tb_top.sv
